### design/bpa_pkg.sv
package bpa_pkg;

  localparam int unsigned PAGE_W    = 11;
  localparam int unsigned CNT_W     = 12;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned STATUS_W  = 2;

  localparam int unsigned MAX_WORDS_DEF = 64;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned CFG_RESET     = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2,
    ST_DUP   = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

endpackage

### design/bpa_bitmap_mem.sv
module bpa_bitmap_mem #(
  parameter int unsigned DEPTH = bpa_pkg::MAX_WORDS_DEF,
  parameter int unsigned WIDTH = bpa_pkg::WORD_BITS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/bpa_page_split.sv
module bpa_page_split #(
  parameter int unsigned WORD_BITS = bpa_pkg::WORD_BITS_DEF,
  localparam int unsigned BIT_W    = $clog2(WORD_BITS),
  localparam int unsigned QW       = $clog2((2048 / WORD_BITS) + 1)
) (
  input  logic [bpa_pkg::PAGE_W-1:0] page_i,
  output logic [QW-1:0]              word_o,
  output logic [BIT_W-1:0]           bit_o
);

  localparam int unsigned PW = bpa_pkg::PAGE_W;
  localparam int unsigned DW = PW + 1;

  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic [QW-1:0] quo;

  always_comb begin
    rem = DW'(page_i);
    quo = '0;
    dv  = '0;
    for (int k = QW - 1; k >= 0; k--) begin
      dv = DW'(WORD_BITS) << k;
      if (rem >= dv) begin
        rem    = rem - dv;
        quo[k] = 1'b1;
      end
    end
  end

  assign word_o = quo;
  assign bit_o  = rem[BIT_W-1:0];

endmodule

### design/bpa_lsb_find.sv
module bpa_lsb_find #(
  parameter int unsigned WORD_BITS = bpa_pkg::WORD_BITS_DEF,
  localparam int unsigned BIT_W    = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word_i,
  output logic [BIT_W-1:0]     bit_o,
  output logic [WORD_BITS-1:0] cleared_o
);

  logic [WORD_BITS-1:0] low;

  assign low       = word_i & (~word_i + WORD_BITS'(1));
  assign cleared_o = word_i & ~low;

  always_comb begin
    bit_o = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (((j >> k) & 1) == 1) begin
          bit_o[k] = bit_o[k] | low[j];
        end
      end
    end
  end

endmodule

### design/bitmap_page_allocator.sv
// Page allocator over a bitmap of free pages held in a single-port-read,
// single-port-write RAM of MAX_WORDS words of WORD_BITS bits (set bit = free
// page). After reset the RAM is cleared one word per cycle, with in_stall_o
// high; words_in_use can be written at any time through the cfg port. A free
// request checks its word against the word count, reads the bitmap word, then
// sets the bit and writes it back, or flags a duplicate; an out-of-range page
// skips the read. An allocate request reads bitmap words from the search
// hint, one RAM read then one check or write back per word, until a word with
// a free page is found or the scan runs off the word count; a refused allocate
// on a zero count goes straight to the result. Each result is then loaded into
// the output register. One request is worked at a time; the next can be
// accepted in the cycle after the result is loaded, while that result waits.
module bitmap_page_allocator #(
  parameter int unsigned MAX_WORDS = bpa_pkg::MAX_WORDS_DEF,
  parameter int unsigned WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_func_i,
  input  logic [bpa_pkg::PAGE_W-1:0]          in_page_number_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bpa_pkg::STATUS_W-1:0]        out_status_o,
  output logic [bpa_pkg::PAGE_W-1:0]          out_allocated_page_o,
  output logic [bpa_pkg::CNT_W-1:0]           out_free_pages_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpa_pkg::CFG_W-1:0]           cfg_words_in_use_i
);

  localparam int unsigned WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned HINT_W = $clog2(MAX_WORDS + 1);
  localparam int unsigned BIT_W  = $clog2(WORD_BITS);
  localparam int unsigned QW     = $clog2((2048 / WORD_BITS) + 1);
  localparam int unsigned LW0    = (HINT_W > bpa_pkg::CFG_W) ? HINT_W : bpa_pkg::CFG_W;
  localparam int unsigned LIM_W  = (LW0 > QW) ? LW0 : QW;
  localparam int unsigned GP_W   = HINT_W + BIT_W + 1 + bpa_pkg::PAGE_W;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_FREE_RD  = 7'b0000100,
    S_FREE_WR  = 7'b0001000,
    S_SCAN     = 7'b0010000,
    S_SCAN_CHK = 7'b0100000,
    S_RESP     = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  logic [WIDX_W-1:0]             clr_q, clr_d;
  logic [bpa_pkg::CFG_W-1:0]     cfg_q;
  logic [HINT_W-1:0]             hint_q, hint_d;
  logic [HINT_W-1:0]             ptr_q, ptr_d;
  logic [bpa_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          func_q;
  logic [QW-1:0]                 wi_q;
  logic [BIT_W-1:0]              bit_q;
  bpa_pkg::status_e              res_status_q, res_status_d;
  logic [bpa_pkg::PAGE_W-1:0]    res_page_q, res_page_d;
  logic                          out_valid_q, out_valid_d;
  bpa_pkg::status_e              out_status_q;
  logic [bpa_pkg::PAGE_W-1:0]    out_page_q;
  logic [bpa_pkg::CNT_W-1:0]     out_count_q;

  logic                          in_acc;
  logic                          out_load;
  logic [QW-1:0]                 in_wi;
  logic [BIT_W-1:0]              in_bit;
  logic [LIM_W-1:0]              cfg_ext;
  logic [LIM_W-1:0]              limit;
  logic [LIM_W-1:0]              wi_ext;
  logic [LIM_W-1:0]              ptr_ext;
  logic [LIM_W-1:0]              hint_ext;
  logic                          rd_en;
  logic [WIDX_W-1:0]             rd_addr;
  logic [WORD_BITS-1:0]          rd_data;
  logic                          wr_en;
  logic [WIDX_W-1:0]             wr_addr;
  logic [WORD_BITS-1:0]          wr_data;
  logic [BIT_W-1:0]              lsb;
  logic [WORD_BITS-1:0]          cleared;
  logic [GP_W-1:0]               grant;

  bpa_page_split #(
    .WORD_BITS (WORD_BITS)
  ) u_split (
    .page_i (in_page_number_i),
    .word_o (in_wi),
    .bit_o  (in_bit)
  );

  bpa_lsb_find #(
    .WORD_BITS (WORD_BITS)
  ) u_lsb (
    .word_i    (rd_data),
    .bit_o     (lsb),
    .cleared_o (cleared)
  );

  bpa_bitmap_mem #(
    .DEPTH (MAX_WORDS),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign cfg_ext  = LIM_W'(cfg_q);
  assign limit    = (cfg_ext < LIM_W'(MAX_WORDS)) ? cfg_ext : LIM_W'(MAX_WORDS);
  assign wi_ext   = LIM_W'(wi_q);
  assign ptr_ext  = LIM_W'(ptr_q);
  assign hint_ext = LIM_W'(hint_q);
  assign grant    = GP_W'(ptr_q) * GP_W'(WORD_BITS) + GP_W'(lsb);

  assign out_load = (state_q == S_RESP) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    hint_d       = hint_q;
    ptr_d        = ptr_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + WIDX_W'(1);
        if (clr_q == WIDX_W'(MAX_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_page_d = '0;
          if (in_func_i == bpa_pkg::FUNC_FREE) begin
            state_d = S_FREE_RD;
          end else if (count_q == '0) begin
            res_status_d = bpa_pkg::ST_NONE;
            state_d      = S_RESP;
          end else begin
            ptr_d   = hint_q;
            state_d = S_SCAN;
          end
        end
      end
      S_FREE_RD: begin
        if (wi_ext >= limit) begin
          res_status_d = bpa_pkg::ST_RANGE;
          state_d      = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = wi_ext[WIDX_W-1:0];
          state_d = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        if (rd_data[bit_q]) begin
          res_status_d = bpa_pkg::ST_DUP;
        end else begin
          wr_en   = 1'b1;
          wr_addr = wi_ext[WIDX_W-1:0];
          wr_data = rd_data | (WORD_BITS'(1) << bit_q);
          if (wi_ext < hint_ext) begin
            hint_d = wi_ext[HINT_W-1:0];
          end
          if (count_q != bpa_pkg::COUNT_MAX) begin
            count_d = count_q + bpa_pkg::CNT_W'(1);
          end
          res_status_d = bpa_pkg::ST_OK;
        end
        state_d = S_RESP;
      end
      S_SCAN: begin
        if (ptr_ext >= limit) begin
          res_status_d = bpa_pkg::ST_NONE;
          state_d      = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_ext[WIDX_W-1:0];
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (rd_data == '0) begin
          ptr_d   = ptr_q + HINT_W'(1);
          state_d = S_SCAN;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = ptr_ext[WIDX_W-1:0];
          wr_data      = cleared;
          hint_d       = (cleared != '0) ? ptr_q : ptr_q + HINT_W'(1);
          count_d      = count_q - bpa_pkg::CNT_W'(1);
          res_status_d = bpa_pkg::ST_OK;
          res_page_d   = grant[bpa_pkg::PAGE_W-1:0];
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cfg_q       <= bpa_pkg::CFG_W'(bpa_pkg::CFG_RESET);
      hint_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_words_in_use_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    if (in_acc) begin
      func_q <= in_func_i;
      wi_q   <= in_wi;
      bit_q  <= in_bit;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_page_q   <= (func_q == bpa_pkg::FUNC_ALLOC) ? res_page_q : '0;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_o         = out_status_q;
  assign out_allocated_page_o = out_page_q;
  assign out_free_pages_o     = out_count_q;

endmodule

### tb/page_alloc_checker.sv
module page_alloc_checker #(
  parameter int unsigned MAX_WORDS = bpa_pkg::MAX_WORDS_DEF,
  parameter int unsigned WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         in_func_i,
  input  logic [bpa_pkg::PAGE_W-1:0]   in_page_number_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [bpa_pkg::STATUS_W-1:0] out_status_i,
  input  logic [bpa_pkg::PAGE_W-1:0]   out_allocated_page_i,
  input  logic [bpa_pkg::CNT_W-1:0]    out_free_pages_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [bpa_pkg::CFG_W-1:0]    cfg_words_in_use_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  outstanding_o,
  output int unsigned                  compared_o,
  output int unsigned                  granted_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bpa_pkg::status_e           status;
    logic [bpa_pkg::PAGE_W-1:0] page;
    logic [bpa_pkg::CNT_W-1:0]  count;
  } page_reply_t;

  logic [WORD_BITS-1:0]      free_map [MAX_WORDS];
  int unsigned               scan_start;
  logic [bpa_pkg::CNT_W-1:0] free_total;
  logic [bpa_pkg::CFG_W-1:0] word_limit_cfg;
  page_reply_t               pending_replies [$];
  int unsigned               mismatches;
  int unsigned               compared;
  int unsigned               granted;

  initial begin
    for (int w = 0; w < MAX_WORDS; w++) free_map[w] = '0;
    scan_start     = 0;
    free_total     = '0;
    word_limit_cfg = bpa_pkg::CFG_W'(bpa_pkg::CFG_RESET);
    mismatches     = 0;
    compared       = 0;
    granted        = 0;
  end

  function automatic page_reply_t apply_request(bpa_pkg::func_e op,
                                                logic [bpa_pkg::PAGE_W-1:0] page);
    page_reply_t r;
    int unsigned lim;
    int unsigned w;
    int unsigned b;
    int unsigned pg_num;
    bit          hit;
    lim      = (word_limit_cfg < MAX_WORDS) ? word_limit_cfg : MAX_WORDS;
    r.status = bpa_pkg::ST_NONE;
    r.page   = '0;
    hit      = 1'b0;
    if (op == bpa_pkg::FUNC_ALLOC) begin
      if (free_total != '0) begin
        for (w = scan_start; w < lim && !hit; w++) begin
          if (free_map[w] != '0) begin
            b = 0;
            while (!free_map[w][b]) b++;
            free_map[w][b] = 1'b0;
            scan_start     = (free_map[w] != '0) ? w : w + 1;
            free_total     = free_total - 1'b1;
            pg_num         = w * WORD_BITS + b;
            r.page         = pg_num[bpa_pkg::PAGE_W-1:0];
            r.status       = bpa_pkg::ST_OK;
            hit            = 1'b1;
          end
        end
      end
    end else begin
      w = page / WORD_BITS;
      b = page % WORD_BITS;
      if (w >= lim) begin
        r.status = bpa_pkg::ST_RANGE;
      end else if (free_map[w][b]) begin
        r.status = bpa_pkg::ST_DUP;
      end else begin
        free_map[w][b] = 1'b1;
        if (w < scan_start) scan_start = w;
        if (free_total != bpa_pkg::COUNT_MAX) free_total = free_total + 1'b1;
        r.status = bpa_pkg::ST_OK;
      end
    end
    r.count = free_total;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got_v,
                               input int unsigned exp_v);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got_v, exp_v);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : watch_channels
    page_reply_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) word_limit_cfg = cfg_words_in_use_i;
      if (out_valid_i && !out_stall_i) begin
        if (pending_replies.size() == 0) begin
          flag_mismatch("result with no request outstanding, status", out_status_i, 0);
        end else begin
          want = pending_replies.pop_front();
          compared++;
          if (out_status_i !== want.status)
            flag_mismatch("status", out_status_i, want.status);
          if (out_allocated_page_i !== want.page)
            flag_mismatch("allocated_page", out_allocated_page_i, want.page);
          if (out_free_pages_i !== want.count)
            flag_mismatch("free_pages", out_free_pages_i, want.count);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = apply_request(bpa_pkg::func_e'(in_func_i), in_page_number_i);
        if (want.status == bpa_pkg::ST_OK && bpa_pkg::func_e'(in_func_i) == bpa_pkg::FUNC_ALLOC)
          granted++;
        pending_replies.push_back(want);
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= pending_replies.size();
    compared_o    <= compared;
    granted_o     <= granted;
  end

endmodule

### tb/bitmap_page_allocator_tb.sv
module bitmap_page_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_WORDS    = bpa_pkg::MAX_WORDS_DEF;
  localparam int unsigned WORD_BITS    = bpa_pkg::WORD_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS  = 245;
  localparam int unsigned HOT_PAGES    = 48;

  logic                         clk_i              = 1'b0;
  logic                         rst_ni             = 1'b0;
  logic                         in_valid_i         = 1'b0;
  logic                         in_stall_o;
  logic                         in_func_i          = 1'b0;
  logic [bpa_pkg::PAGE_W-1:0]   in_page_number_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i        = 1'b0;
  logic [bpa_pkg::STATUS_W-1:0] out_status_o;
  logic [bpa_pkg::PAGE_W-1:0]   out_allocated_page_o;
  logic [bpa_pkg::CNT_W-1:0]    out_free_pages_o;
  logic                         cfg_valid_i        = 1'b0;
  logic                         cfg_ready_o;
  logic [bpa_pkg::CFG_W-1:0]    cfg_words_in_use_i = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned compared;
  int unsigned granted;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned issued         = 0;
  int unsigned settings       = 0;
  int unsigned lim_words      = bpa_pkg::CFG_RESET;
  logic        hold_on        = 1'b0;
  event        hold_ev;

  bitmap_page_allocator #(
    .MAX_WORDS(MAX_WORDS),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_func_i           (in_func_i),
    .in_page_number_i    (in_page_number_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_o        (out_status_o),
    .out_allocated_page_o(out_allocated_page_o),
    .out_free_pages_o    (out_free_pages_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_words_in_use_i  (cfg_words_in_use_i)
  );

  page_alloc_checker #(
    .MAX_WORDS(MAX_WORDS),
    .WORD_BITS(WORD_BITS)
  ) grant_watch (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .in_func_i           (in_func_i),
    .in_page_number_i    (in_page_number_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_i        (out_status_o),
    .out_allocated_page_i(out_allocated_page_o),
    .out_free_pages_i    (out_free_pages_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_words_in_use_i  (cfg_words_in_use_i),
    .mismatches_o        (mismatches),
    .outstanding_o       (outstanding),
    .compared_o          (compared),
    .granted_o           (granted)
  );

  always #2ns clk_i = ~clk_i;

  always @(posedge clk_i) out_stall_i <= hold_on || ($urandom_range(99) < recv_stall_pct);

  always begin
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic issue_request(input bpa_pkg::func_e op,
                               input logic [bpa_pkg::PAGE_W-1:0] page);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_func_i        <= op;
    in_page_number_i <= page;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    issued++;
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_word_limit(input logic [bpa_pkg::CFG_W-1:0] words);
    drain_replies();
    cfg_valid_i        <= 1'b1;
    cfg_words_in_use_i <= words;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    settings++;
    lim_words = (words < MAX_WORDS) ? words : MAX_WORDS;
  endtask

  task automatic random_request(input int unsigned alloc_pct);
    logic [bpa_pkg::PAGE_W-1:0] page;
    int unsigned                roll;
    int unsigned                span;
    roll = $urandom_range(99);
    page = bpa_pkg::PAGE_W'($urandom);
    span = lim_words * WORD_BITS;
    if (roll < 8) begin
      issue_request(bpa_pkg::FUNC_FREE, page);
    end else if (roll < 8 + alloc_pct * 92 / 100) begin
      issue_request(bpa_pkg::FUNC_ALLOC, page);
    end else begin
      if (span > HOT_PAGES && $urandom_range(1))
        page = bpa_pkg::PAGE_W'($urandom_range(HOT_PAGES - 1));
      else if (span != 0)
        page = bpa_pkg::PAGE_W'($urandom_range(span - 1));
      issue_request(bpa_pkg::FUNC_FREE, page);
    end
  endtask

  initial begin : stimulus
    logic [bpa_pkg::CFG_W-1:0] phase_limits [8];
    int unsigned               n_items;
    int unsigned               mode;
    phase_limits = '{7'd64, 7'd127, 7'd8, 7'd1, 7'd64, 7'd0, 7'd64, 7'd2};
    phase_limits[6] = bpa_pkg::CFG_W'($urandom_range(63, 2));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue_request(bpa_pkg::FUNC_ALLOC, 11'h7FF);
    issue_request(bpa_pkg::FUNC_FREE, 11'd0);
    issue_request(bpa_pkg::FUNC_FREE, 11'd1);
    issue_request(bpa_pkg::FUNC_FREE, 11'd2047);
    issue_request(bpa_pkg::FUNC_FREE, 11'd2047);
    issue_request(bpa_pkg::FUNC_FREE, 11'd40);
    repeat (5) issue_request(bpa_pkg::FUNC_ALLOC, 11'h7FF);
    set_word_limit(7'd127);
    issue_request(bpa_pkg::FUNC_FREE, 11'd2047);
    issue_request(bpa_pkg::FUNC_FREE, 11'd1024);
    set_word_limit(7'd1);
    issue_request(bpa_pkg::FUNC_FREE, 11'd32);
    issue_request(bpa_pkg::FUNC_FREE, 11'd5);
    issue_request(bpa_pkg::FUNC_ALLOC, 11'd0);
    issue_request(bpa_pkg::FUNC_ALLOC, 11'd0);
    set_word_limit(7'd0);
    issue_request(bpa_pkg::FUNC_FREE, 11'd0);
    issue_request(bpa_pkg::FUNC_ALLOC, 11'd0);
    set_word_limit(7'd64);
    issue_request(bpa_pkg::FUNC_ALLOC, 11'h555);
    issue_request(bpa_pkg::FUNC_ALLOC, 11'h2AA);
    issue_request(bpa_pkg::FUNC_FREE, 11'd31);
    issue_request(bpa_pkg::FUNC_ALLOC, 11'd0);

    for (int p = 0; p < 8; p++) begin
      mode           = p % 4;
      send_idle_pct  = (mode == 1) ? 60 : (mode == 3) ? 10 : 0;
      recv_stall_pct = (mode == 2) ? 60 : (mode == 3) ? 10 : 0;
      set_word_limit(phase_limits[p]);
      n_items = (phase_limits[p] == 0) ? 40 : PHASE_ITEMS;
      for (int i = 0; i < n_items; i++) begin
        if (p == 2 && i == 20) -> hold_ev;
        if (p == 4 && i == n_items / 2) drain_replies();
        random_request((p % 2 == 1) ? 65 : 35);
      end
    end

    drain_replies();
    $display("Covered %0d requests under %0d word-count writes; %0d results compared,",
             issued, settings, compared);
    $display("%0d pages granted; idle mixes none/sender/receiver/both plus a long hold.",
             granted);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/bpa_pkg.sv
design/bpa_bitmap_mem.sv
design/bpa_page_split.sv
design/bpa_lsb_find.sv
design/bitmap_page_allocator.sv
tb/page_alloc_checker.sv
tb/bitmap_page_allocator_tb.sv
